[src/bubble_sort_ist_parent_assert.svh]
// Assertion macros for the bubble-sort spanning tree parent block
`ifndef BUBBLE_SORT_IST_PARENT_ASSERT_SVH
`define BUBBLE_SORT_IST_PARENT_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define BSIST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define BSIST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BSIST_ASSERT(lbl, prop, msg)

`define BSIST_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[src/bsist_pkg.sv]
package bsist_pkg;

  localparam int N     = 10;
  localparam int SymW  = 4;
  localparam int PermW = 40;
  localparam int TreeW = 4;

  localparam logic [SymW-1:0] NSym     = SymW'(N);
  localparam logic [SymW-1:0] Nm1Sym   = SymW'(N - 1);
  localparam logic [SymW-1:0] OneSym   = SymW'(1);
  localparam logic [SymW-1:0] TwoSym   = SymW'(2);

  typedef struct packed {
    logic            en;
    logic [SymW-1:0] val;
  } sym_t;

  typedef struct packed {
    logic             valid;
    logic [PermW-1:0] perm;
    sym_t             sym_a;
    sym_t             sym_b;
    logic             alt;
  } dec_stage_t;

  typedef struct packed {
    logic             valid;
    logic [PermW-1:0] perm_a;
    logic [PermW-1:0] perm_b;
    logic             alt;
  } swp_stage_t;

endpackage

[src/bsist_swap.sv]
module bsist_swap (
  input  logic [bsist_pkg::PermW-1:0] perm_i,
  input  bsist_pkg::sym_t             sym_i,
  output logic [bsist_pkg::PermW-1:0] perm_o
);

  logic [bsist_pkg::N-1:0]     match;
  logic [bsist_pkg::N-1:0]     hit;
  logic [bsist_pkg::N-1:0]     take_next;
  logic [bsist_pkg::N-1:0]     take_prev;
  logic [bsist_pkg::PermW-1:0] next_perm;
  logic [bsist_pkg::PermW-1:0] prev_perm;

  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < bsist_pkg::N; i++) begin
      match[i] = sym_i.en &&
                 (perm_i[i*bsist_pkg::SymW +: bsist_pkg::SymW] == sym_i.val);
      hit[i]   = match[i] && !seen;
      seen     = seen | match[i];
    end
  end

  // drop a hit in the last position: nothing to its right
  assign take_next = hit & ~(bsist_pkg::N'(1) << (bsist_pkg::N - 1));
  assign take_prev = take_next << 1;
  assign next_perm = perm_i >> bsist_pkg::SymW;
  assign prev_perm = perm_i << bsist_pkg::SymW;

  always_comb begin
    perm_o = perm_i;
    for (int i = 0; i < bsist_pkg::N; i++) begin
      if (take_next[i]) begin
        perm_o[i*bsist_pkg::SymW +: bsist_pkg::SymW] =
          next_perm[i*bsist_pkg::SymW +: bsist_pkg::SymW];
      end else if (take_prev[i]) begin
        perm_o[i*bsist_pkg::SymW +: bsist_pkg::SymW] =
          prev_perm[i*bsist_pkg::SymW +: bsist_pkg::SymW];
      end
    end
  end

endmodule

[src/bubble_sort_ist_parent.sv]
// Channel   | Handshake          | Payload
// ----------+--------------------+------------------------------
// command   | start_i, busy_o    | vertex_perm_i, tree_index_i
// result    | done_o (strobe)    | parent_perm_o
//
// One transaction per cycle; the result passes through the decode, swap and output registers.
// Stages: rule decode, two parallel symbol swaps, identity check and select.
// busy_o stays low: the pipeline never stalls, as the receiver cannot hold off.
// Reset clears all stage registers; results start with the next start_i.
module bubble_sort_ist_parent (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [bsist_pkg::PermW-1:0]   vertex_perm_i,
  input  logic [bsist_pkg::TreeW-1:0]   tree_index_i,
  output logic                          done_o,
  output logic [bsist_pkg::PermW-1:0]   parent_perm_o
);

  `include "bubble_sort_ist_parent_assert.svh"

  bsist_pkg::dec_stage_t dec_d, dec_q;
  bsist_pkg::swp_stage_t swp_d, swp_q;
  logic                          done_q;
  logic [bsist_pkg::PermW-1:0]   perm_q, perm_d;
  logic [bsist_pkg::PermW-1:0]   swap_a, swap_b;
  logic                          is_ident;

  assign busy_o = 1'b0;

  always_comb begin
    logic [bsist_pkg::SymW-1:0] a [bsist_pkg::N];
    logic [bsist_pkg::SymW-1:0] t;
    logic [bsist_pkg::SymW-1:0] wrong_sym;
    logic                       wrong_any;
    logic                       head_ok;
    t         = bsist_pkg::SymW'(tree_index_i);
    wrong_sym = '0;
    wrong_any = 1'b0;
    head_ok   = 1'b1;
    for (int i = 0; i < bsist_pkg::N; i++) begin
      a[i] = vertex_perm_i[i*bsist_pkg::SymW +: bsist_pkg::SymW];
      if (a[i] != bsist_pkg::SymW'(i + 1)) begin
        wrong_any = 1'b1;
        wrong_sym = a[i];
      end
      if ((i < bsist_pkg::N - 2) && (a[i] != bsist_pkg::SymW'(i + 1))) begin
        head_ok = 1'b0;
      end
    end

    dec_d.valid = start_i;
    dec_d.perm  = vertex_perm_i;
    dec_d.sym_a = '{en: 1'b1, val: t};
    dec_d.sym_b = '{en: 1'b1, val: bsist_pkg::OneSym};
    dec_d.alt   = 1'b0;

    if (a[bsist_pkg::N-1] == bsist_pkg::NSym) begin
      if (t == bsist_pkg::Nm1Sym) begin
        dec_d.sym_a.val = a[bsist_pkg::N-2];
      end else if (t == bsist_pkg::TwoSym) begin
        dec_d.sym_a.val = bsist_pkg::TwoSym;
        dec_d.alt       = 1'b1;
      end else if ((a[bsist_pkg::N-2] == t) ||
                   (a[bsist_pkg::N-2] == bsist_pkg::Nm1Sym)) begin
        if (wrong_any) begin
          dec_d.sym_a.val = wrong_sym;
        end
      end
    end else if ((a[bsist_pkg::N-1] == bsist_pkg::Nm1Sym) &&
                 (a[bsist_pkg::N-2] == bsist_pkg::NSym) && !head_ok) begin
      if (t == bsist_pkg::OneSym) begin
        dec_d.sym_a.val = bsist_pkg::NSym;
      end else begin
        dec_d.sym_a = '{en: (t != '0), val: t - bsist_pkg::OneSym};
      end
    end else if (a[bsist_pkg::N-1] == t) begin
      dec_d.sym_a.val = bsist_pkg::NSym;
    end
  end

  bsist_swap u_swap_a (
    .perm_i (dec_q.perm),
    .sym_i  (dec_q.sym_a),
    .perm_o (swap_a)
  );

  bsist_swap u_swap_b (
    .perm_i (dec_q.perm),
    .sym_i  (dec_q.sym_b),
    .perm_o (swap_b)
  );

  assign swp_d = '{valid: dec_q.valid, perm_a: swap_a, perm_b: swap_b, alt: dec_q.alt};

  always_comb begin
    is_ident = 1'b1;
    for (int i = 0; i < bsist_pkg::N; i++) begin
      if (swp_q.perm_a[i*bsist_pkg::SymW +: bsist_pkg::SymW] !=
          bsist_pkg::SymW'(i + 1)) begin
        is_ident = 1'b0;
      end
    end
  end

  assign perm_d = (swp_q.alt && is_ident) ? swp_q.perm_b : swp_q.perm_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q  <= '0;
      swp_q  <= '0;
      done_q <= 1'b0;
      perm_q <= '0;
    end else begin
      dec_q.valid <= dec_d.valid;
      swp_q.valid <= swp_d.valid;
      done_q      <= swp_q.valid;
      if (dec_d.valid) begin
        dec_q.perm  <= dec_d.perm;
        dec_q.sym_a <= dec_d.sym_a;
        dec_q.sym_b <= dec_d.sym_b;
        dec_q.alt   <= dec_d.alt;
      end
      if (swp_d.valid) begin
        swp_q.perm_a <= swp_d.perm_a;
        swp_q.perm_b <= swp_d.perm_b;
        swp_q.alt    <= swp_d.alt;
      end
      if (swp_q.valid) begin
        perm_q <= perm_d;
      end
    end
  end

  assign done_o        = done_q;
  assign parent_perm_o = perm_q;

  `BSIST_ASSERT_NEXT(a_latency, start_i && !busy_o, ##2 done_o, "result strobe missing")
  `BSIST_ASSERT(a_hold, !done_o |-> $stable(parent_perm_o), "result changed without strobe")
  `BSIST_ASSERT(a_valid_chain, done_o |-> $past(dec_q.valid, 2), "strobe without decode")

endmodule

[test/bubble_sort_ist_parent_checker.sv]
module bubble_sort_ist_parent_checker
  import bsist_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_o,
  input  logic [PermW-1:0] vertex_perm_i,
  input  logic [TreeW-1:0] tree_index_i,
  input  logic             done_o,
  input  logic [PermW-1:0] parent_perm_o,
  output int               error_count,
  output int               pending_count
);

  logic [PermW-1:0] expected_parents[$];

  function automatic logic [PermW-1:0] swap_symbol(input logic [PermW-1:0] p,
                                                   input logic [SymW-1:0]  x);
    logic [PermW-1:0] r;
    logic             hit;
    r   = p;
    hit = 1'b0;
    for (int i = 0; i < N; i++) begin
      if (!hit && p[SymW*i +: SymW] == x) begin
        hit = 1'b1;
        if (i + 1 < N) begin
          r[SymW*i +: SymW]     = p[SymW*(i+1) +: SymW];
          r[SymW*(i+1) +: SymW] = p[SymW*i +: SymW];
        end
      end
    end
    return r;
  endfunction

  function automatic logic is_identity(input logic [PermW-1:0] p);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < N; i++) begin
      if (p[SymW*i +: SymW] != SymW'(i + 1)) ok = 1'b0;
    end
    return ok;
  endfunction

  // 1-based position of the rightmost misplaced symbol, 0 if sorted
  function automatic int last_misplaced(input logic [PermW-1:0] p);
    int pos;
    pos = 0;
    for (int i = 1; i <= N; i++) begin
      if (p[SymW*(i-1) +: SymW] != SymW'(i)) pos = i;
    end
    return pos;
  endfunction

  function automatic logic [PermW-1:0] tree_parent(input logic [PermW-1:0] a,
                                                   input logic [TreeW-1:0] t);
    logic [SymW-1:0]  last_sym;
    logic [SymW-1:0]  prev_sym;
    logic [PermW-1:0] r;
    int               j;
    last_sym = a[SymW*(N-1) +: SymW];
    prev_sym = a[SymW*(N-2) +: SymW];
    if (last_sym == NSym) begin
      if (t == Nm1Sym) begin
        r = swap_symbol(a, prev_sym);
      end else if (t == TwoSym) begin
        r = swap_symbol(a, TwoSym);
        if (is_identity(r)) r = swap_symbol(a, OneSym);
      end else if (prev_sym == t || prev_sym == Nm1Sym) begin
        j = last_misplaced(a);
        if (j > 0) r = swap_symbol(a, a[SymW*(j-1) +: SymW]);
        else r = swap_symbol(a, t);
      end else begin
        r = swap_symbol(a, t);
      end
    end else if (last_sym == Nm1Sym && prev_sym == NSym &&
                 !is_identity(swap_symbol(a, NSym))) begin
      // tree zero: t-1 names no symbol, so nothing moves
      if (t == OneSym) r = swap_symbol(a, NSym);
      else if (t == '0) r = a;
      else r = swap_symbol(a, t - OneSym);
    end else if (last_sym == t) begin
      r = swap_symbol(a, NSym);
    end else begin
      r = swap_symbol(a, t);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [PermW-1:0] exp_perm;
    if (!rst_ni) begin
      expected_parents.delete();
      error_count   <= 0;
      pending_count <= 0;
    end else begin
      if (done_o) begin
        if (expected_parents.size() == 0) begin
          $error("parent_perm: unexpected result %h", parent_perm_o);
          error_count <= error_count + 1;
        end else begin
          exp_perm = expected_parents.pop_front();
          if (parent_perm_o !== exp_perm) begin
            $error("parent_perm: expected %h, actual %h", exp_perm, parent_perm_o);
            error_count <= error_count + 1;
          end
        end
      end
      if (start_i && !busy_o) begin
        expected_parents.push_back(tree_parent(vertex_perm_i, tree_index_i));
      end
      pending_count <= expected_parents.size();
    end
  end

endmodule

[test/tb_top.sv]
module tb_top;
  import bsist_pkg::*;

  typedef enum int {
    VtxShuffle,
    VtxNearSorted,
    VtxLastN,
    VtxTailNNm1,
    VtxNoise
  } vertex_kind_e;

  localparam int NumRandom = 900;

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic [PermW-1:0] vertex_perm_i;
  logic [TreeW-1:0] tree_index_i;
  logic             done_o;
  logic [PermW-1:0] parent_perm_o;
  logic             accept_q;
  int               error_count;
  int               pending_count;

  bubble_sort_ist_parent uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .vertex_perm_i (vertex_perm_i),
    .tree_index_i  (tree_index_i),
    .done_o        (done_o),
    .parent_perm_o (parent_perm_o)
  );

  bubble_sort_ist_parent_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .vertex_perm_i (vertex_perm_i),
    .tree_index_i  (tree_index_i),
    .done_o        (done_o),
    .parent_perm_o (parent_perm_o),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accept_q <= 1'b0;
    end else begin
      accept_q <= start_i && !busy_o;
    end
  end

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_vertex(input logic [PermW-1:0] perm, input logic [TreeW-1:0] tree);
    start_i       <= 1'b1;
    vertex_perm_i <= perm;
    tree_index_i  <= tree;
    do @(negedge clk_i); while (!accept_q);
  endtask

  task automatic idle_cycles(input int n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending_count != 0) @(negedge clk_i);
  endtask

  function automatic logic [PermW-1:0] make_vertex(input vertex_kind_e kind);
    logic [SymW-1:0]  s[N];
    logic [SymW-1:0]  tmp;
    logic [PermW-1:0] p;
    int               j;
    int               k;
    for (int i = 0; i < N; i++) s[i] = SymW'(i + 1);
    case (kind)
      VtxNearSorted: begin
        k = $urandom_range(3, 0);
        repeat (k) begin
          j = $urandom_range(N - 2, 0);
          tmp = s[j]; s[j] = s[j+1]; s[j+1] = tmp;
        end
      end
      VtxNoise: ;
      default: begin
        for (int i = N - 1; i > 0; i--) begin
          j = $urandom_range(i, 0);
          tmp = s[i]; s[i] = s[j]; s[j] = tmp;
        end
      end
    endcase
    if (kind == VtxLastN || kind == VtxTailNNm1) begin
      for (int i = 0; i < N; i++) begin
        if (s[i] == NSym) begin
          s[i] = s[N-1]; s[N-1] = NSym;
        end
      end
    end
    if (kind == VtxTailNNm1) begin
      for (int i = 0; i < N - 1; i++) begin
        if (s[i] == Nm1Sym) begin
          s[i] = s[N-2]; s[N-2] = Nm1Sym;
        end
      end
      s[N-1] = Nm1Sym;
      s[N-2] = NSym;
    end
    for (int i = 0; i < N; i++) p[SymW*i +: SymW] = s[i];
    if (kind == VtxNoise) begin
      if ($urandom_range(1, 0)) begin
        p = PermW'({$urandom(), $urandom()});
      end else begin
        // duplicate one symbol over another
        j = $urandom_range(N - 1, 0);
        k = $urandom_range(N - 1, 0);
        p[SymW*k +: SymW] = p[SymW*j +: SymW];
      end
    end
    return p;
  endfunction

  function automatic logic [TreeW-1:0] pick_tree(input logic [PermW-1:0] perm);
    int r;
    r = $urandom_range(99, 0);
    if (r < 60) return TreeW'($urandom_range(N - 1, 1));
    if (r < 75) return perm[SymW*(N-2) +: SymW];
    if (r < 82) return perm[SymW*(N-1) +: SymW];
    if (r < 90) return ($urandom_range(1, 0)) ? TwoSym : Nm1Sym;
    return TreeW'($urandom_range(15, 0));
  endfunction

  function automatic vertex_kind_e pick_kind();
    int r;
    r = $urandom_range(99, 0);
    if (r < 25) return VtxShuffle;
    if (r < 45) return VtxNearSorted;
    if (r < 70) return VtxLastN;
    if (r < 85) return VtxTailNNm1;
    return VtxNoise;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  initial begin
    logic [PermW-1:0] perm;
    logic [TreeW-1:0] tree;
    int               burst;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    vertex_perm_i = '0;
    tree_index_i  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int t = 1; t < N; t++) send_vertex(40'hA987654321, TreeW'(t));
    send_vertex(40'h123456789A, 4'd1);
    send_vertex(40'hA987654231, TwoSym);
    send_vertex(40'hA987654312, TwoSym);
    send_vertex(40'h9A87654321, 4'd1);
    send_vertex(40'h9A87654312, 4'd1);
    send_vertex(40'h9A87654312, 4'd4);
    send_vertex(40'h9A87654312, 4'd0);
    send_vertex(40'hA487659321, 4'd4);
    send_vertex(40'hA123456789, Nm1Sym);
    send_vertex(40'h5A98764321, 4'd5);
    send_vertex(40'h1111111111, 4'd1);
    send_vertex(40'h0000000000, 4'd0);
    send_vertex(40'hFFFFFFFFFF, 4'd15);
    send_vertex(40'hA9876543F1, 4'd12);
    drain_results();

    burst = 0;
    for (int n = 0; n < NumRandom; n++) begin
      perm = make_vertex(pick_kind());
      tree = pick_tree(perm);
      send_vertex(perm, tree);
      if (n % 150 == 75) begin
        drain_results();
      end else if (n % 100 == 0) begin
        burst = 30;
      end
      if (burst > 0) begin
        burst--;
      end else begin
        idle_cycles(pick_gap());
      end
    end

    drain_results();
    repeat (8) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
